@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL; clock clk, asynchronous reset arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/usd_pkg.sv @@
`default_nettype none

package usd_pkg;

	localparam int unsigned MAX_VERTICES_DEF = 64;
	localparam int unsigned COUNT_W = 7;
	localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 7'd64;

	localparam int unsigned PC_W = 4;
	typedef logic [PC_W-1:0] step_t;

	// program addresses
	localparam step_t ST_IDLE     = 4'd0;
	localparam step_t ST_INIT     = 4'd1;
	localparam step_t ST_WTEST    = 4'd2;
	localparam step_t ST_WEVAL    = 4'd3;
	localparam step_t ST_CNEXT    = 4'd4;
	localparam step_t ST_FAIL     = 4'd5;
	localparam step_t ST_RINIT    = 4'd6;
	localparam step_t ST_RTEST    = 4'd7;
	localparam step_t ST_REVAL    = 4'd8;
	localparam step_t ST_RBACK    = 4'd9;
	localparam step_t ST_ROWRD    = 4'd10;
	localparam step_t ST_ROWTEST  = 4'd11;
	localparam step_t ST_ROWEVAL  = 4'd12;
	localparam step_t ST_ROWFAIL  = 4'd13;
	localparam step_t ST_FOUND    = 4'd14;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NOT_LAST,
		COND_ROW_EQ_N,
		COND_COL_OK,
		COND_COL_LT_N,
		COND_BIT_CLEAR
	} cond_t;

	typedef enum logic [1:0] {
		ROP_HOLD,
		ROP_CLR,
		ROP_INC_T
	} row_op_t;

	typedef enum logic [1:0] {
		COP_HOLD,
		COP_CLR,
		COP_INC_F
	} col_op_t;

	typedef enum logic {
		ADDR_ROW,
		ADDR_COL
	} addr_sel_t;

	typedef struct packed {
		cond_t     cond;
		step_t     target;
		row_op_t   row_op;
		col_op_t   col_op;
		logic      rd_en;
		addr_sel_t rd_sel;
		logic      emit;
		logic      sink_val;
	} ctrl_word_t;

	function automatic ctrl_word_t cw(cond_t c, step_t t, row_op_t r, col_op_t k,
			logic re, addr_sel_t s, logic e, logic v);
		ctrl_word_t w;
		w.cond     = c;
		w.target   = t;
		w.row_op   = r;
		w.col_op   = k;
		w.rd_en    = re;
		w.rd_sel   = s;
		w.emit     = e;
		w.sink_val = v;
		return w;
	endfunction

	// Microcode: on a true condition jump to target, else fall through.
	function automatic ctrl_word_t ucode_rom(step_t pc);
		ctrl_word_t w;
		case (pc)
			ST_IDLE:    w = cw(COND_NOT_LAST,  ST_IDLE,    ROP_HOLD,  COP_HOLD,  1'b0, ADDR_ROW,
				1'b0, 1'b0);
			ST_INIT:    w = cw(COND_NEVER,     ST_IDLE,    ROP_CLR,   COP_CLR,   1'b0, ADDR_ROW,
				1'b0, 1'b0);
			ST_WTEST:   w = cw(COND_ROW_EQ_N,  ST_RINIT,   ROP_HOLD,  COP_HOLD,  1'b1, ADDR_ROW,
				1'b0, 1'b0);
			ST_WEVAL:   w = cw(COND_COL_OK,    ST_WTEST,   ROP_INC_T, COP_INC_F, 1'b0, ADDR_ROW,
				1'b0, 1'b0);
			ST_CNEXT:   w = cw(COND_COL_LT_N,  ST_WTEST,   ROP_HOLD,  COP_HOLD,  1'b0, ADDR_ROW,
				1'b0, 1'b0);
			ST_FAIL:    w = cw(COND_ALWAYS,    ST_IDLE,    ROP_HOLD,  COP_HOLD,  1'b0, ADDR_ROW,
				1'b1, 1'b0);
			ST_RINIT:   w = cw(COND_NEVER,     ST_IDLE,    ROP_CLR,   COP_HOLD,  1'b0, ADDR_ROW,
				1'b0, 1'b0);
			ST_RTEST:   w = cw(COND_ROW_EQ_N,  ST_ROWRD,   ROP_HOLD,  COP_HOLD,  1'b1, ADDR_ROW,
				1'b0, 1'b0);
			ST_REVAL:   w = cw(COND_COL_OK,    ST_RTEST,   ROP_INC_T, COP_INC_F, 1'b0, ADDR_ROW,
				1'b0, 1'b0);
			ST_RBACK:   w = cw(COND_ALWAYS,    ST_CNEXT,   ROP_HOLD,  COP_HOLD,  1'b0, ADDR_ROW,
				1'b0, 1'b0);
			ST_ROWRD:   w = cw(COND_NEVER,     ST_IDLE,    ROP_CLR,   COP_HOLD,  1'b1, ADDR_COL,
				1'b0, 1'b0);
			ST_ROWTEST: w = cw(COND_ROW_EQ_N,  ST_FOUND,   ROP_HOLD,  COP_HOLD,  1'b0, ADDR_ROW,
				1'b0, 1'b0);
			ST_ROWEVAL: w = cw(COND_BIT_CLEAR, ST_ROWTEST, ROP_INC_T, COP_HOLD,  1'b0, ADDR_ROW,
				1'b0, 1'b0);
			ST_ROWFAIL: w = cw(COND_ALWAYS,    ST_IDLE,    ROP_HOLD,  COP_HOLD,  1'b0, ADDR_ROW,
				1'b1, 1'b0);
			ST_FOUND:   w = cw(COND_ALWAYS,    ST_IDLE,    ROP_HOLD,  COP_HOLD,  1'b0, ADDR_ROW,
				1'b1, 1'b1);
			default:    w = cw(COND_ALWAYS,    ST_IDLE,    ROP_HOLD,  COP_HOLD,  1'b0, ADDR_ROW,
				1'b0, 1'b0);
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

@@ src/universal_sink_detector.sv @@
// Loading: matrix bits load at one per cycle while busy is low, n*n transactions for
// an n-vertex matrix. The search then runs from the microcode table over the single
// read port of the bit store. The result strobe (done, has_sink) is high in the first
// idle cycle after the search. Busy is high during the search, and no matrix bit is
// taken until it ends. Reset (arst_n low): vertex count 64, load position zero,
// program idle, no strobe.
`default_nettype none

`include "assert_macros.svh"

module universal_sink_detector #(
	parameter int unsigned MAX_VERTICES = usd_pkg::MAX_VERTICES_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic                       edge_bit,
	input  wire logic                       cfg_wr_en,
	input  wire logic [usd_pkg::COUNT_W-1:0] cfg_wr_data,
	output logic                            done,
	output logic                            has_sink
);
	import usd_pkg::*;

	localparam int unsigned IDX_W = $clog2(MAX_VERTICES);
	localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1);

	// Configuration and load position
	logic [COUNT_W-1:0] vertex_count_q;
	logic [CNT_W-1:0]   n_eff;
	logic [CNT_W-1:0]   n_m1;
	logic [CNT_W-1:0]   load_row_q;
	logic [CNT_W-1:0]   load_col_q;
	logic [MAX_VERTICES-1:0] row_buf_q;
	logic [MAX_VERTICES-1:0] row_next;

	// Bit store: one row per entry, one write port, one registered read port
	logic [MAX_VERTICES-1:0] adj_mem_q [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] rd_data_q;
	logic [IDX_W-1:0]        rd_addr;

	// Sequencer
	step_t      pc_q;
	ctrl_word_t cword;
	logic       cond_true;
	logic [CNT_W-1:0] walk_row_q;
	logic [CNT_W-1:0] walk_col_q;
	logic       col_ok;
	logic       bit_clear;

	logic accept;
	logic load_en;
	logic last_col;
	logic last_bit;

	// Clamp the count to the store size.
	assign n_eff = (vertex_count_q > COUNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
		: vertex_count_q[CNT_W-1:0];
	assign n_m1  = n_eff - 1'b1;

	assign busy     = (pc_q != ST_IDLE);
	assign accept   = start && !busy;
	// With a zero vertex count a transaction is taken and dropped.
	assign load_en  = accept && (n_eff != '0);
	assign last_col = (load_col_q == n_m1);
	assign last_bit = load_en && last_col && (load_row_q == n_m1);

	always_comb begin
		row_next = row_buf_q;
		row_next[load_col_q[IDX_W-1:0]] = edge_bit;
	end

	// Capture the configuration write and advance the load position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= VERTEX_COUNT_RESET;
			load_row_q     <= '0;
			load_col_q     <= '0;
		end else if (cfg_wr_en) begin
			// drop any partly loaded matrix
			vertex_count_q <= cfg_wr_data;
			load_row_q     <= '0;
			load_col_q     <= '0;
		end else if (load_en) begin
			if (last_col) begin
				load_col_q <= '0;
				load_row_q <= (load_row_q == n_m1) ? '0 : load_row_q + 1'b1;
			end else begin
				load_col_q <= load_col_q + 1'b1;
			end
		end
	end

	// Assemble a row in the buffer, write it to the store when the row closes.
	always_ff @(posedge clk) begin
		if (load_en) begin
			row_buf_q <= row_next;
			if (last_col) begin
				adj_mem_q[load_row_q[IDX_W-1:0]] <= row_next;
			end
		end
		if (cword.rd_en) begin
			rd_data_q <= adj_mem_q[rd_addr];
		end
	end

	// Decode the current control word.
	assign cword   = ucode_rom(pc_q);
	assign rd_addr = (cword.rd_sel == ADDR_COL) ? walk_col_q[IDX_W-1:0]
		: walk_row_q[IDX_W-1:0];

	// A column fits a sink when every off-diagonal bit is set and the diagonal is clear.
	assign col_ok    = (walk_row_q != walk_col_q) ? rd_data_q[walk_col_q[IDX_W-1:0]]
		: !rd_data_q[walk_col_q[IDX_W-1:0]];
	assign bit_clear = !rd_data_q[walk_row_q[IDX_W-1:0]];

	always_comb begin
		case (cword.cond)
			COND_NEVER:     cond_true = 1'b0;
			COND_ALWAYS:    cond_true = 1'b1;
			COND_NOT_LAST:  cond_true = !last_bit;
			COND_ROW_EQ_N:  cond_true = (walk_row_q == n_eff);
			COND_COL_OK:    cond_true = col_ok;
			COND_COL_LT_N:  cond_true = (walk_col_q < n_eff);
			COND_BIT_CLEAR: cond_true = bit_clear;
			default:        cond_true = 1'b0;
		endcase
	end

	// Step counter, walk position and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q       <= ST_IDLE;
			walk_row_q <= '0;
			walk_col_q <= '0;
			done       <= 1'b0;
			has_sink   <= 1'b0;
		end else begin
			pc_q <= cond_true ? cword.target : pc_q + 1'b1;

			case (cword.row_op)
				ROP_HOLD:  walk_row_q <= walk_row_q;
				ROP_CLR:   walk_row_q <= '0;
				ROP_INC_T: walk_row_q <= cond_true ? walk_row_q + 1'b1 : walk_row_q;
				default:   walk_row_q <= walk_row_q;
			endcase

			case (cword.col_op)
				COP_HOLD:  walk_col_q <= walk_col_q;
				COP_CLR:   walk_col_q <= '0;
				COP_INC_F: walk_col_q <= cond_true ? walk_col_q : walk_col_q + 1'b1;
				default:   walk_col_q <= walk_col_q;
			endcase

			done <= cword.emit;
			if (cword.emit) begin
				has_sink <= cword.sink_val;
			end
		end
	end

	// The walk position still holds the previous search in the init step.
	`ASSERT_IMPL(a_done_when_idle, done, !busy, "result strobe while search running")
	`ASSERT_NEXT(a_last_bit_starts, last_bit, busy, "search did not start after last bit")
	`ASSERT_IMPL(a_walk_in_range, busy && (pc_q != ST_INIT),
		(walk_row_q <= n_eff) && (walk_col_q <= n_eff), "walk position beyond vertex count")

endmodule

`default_nettype wire

@@ test/sink_verdict_checker.sv @@
// Watches the item, configuration and result channels of the sink detector,
// keeps its own copy of the matrix and predicts each verdict.
module sink_verdict_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic                        busy,
	input  wire logic                        edge_bit,
	input  wire logic                        cfg_wr_en,
	input  wire logic [usd_pkg::COUNT_W-1:0] cfg_wr_data,
	input  wire logic                        done,
	input  wire logic                        has_sink,
	output int                               fail_count,
	output int                               results_owed
);
	import usd_pkg::*;

	logic [MAX_VERTICES_DEF-1:0] adj_rows [MAX_VERTICES_DEF];
	logic [COUNT_W-1:0]          count_reg;
	int                          fill_row;
	int                          fill_col;
	int                          span;
	int                          errors = 0;
	logic                        want;
	logic                        owed_verdicts [$];

	// Entry (r, c) suits a sink in column c: edge off the diagonal, none on it.
	function automatic logic column_fits(input int r, input int c);
		return (r != c) ? adj_rows[r][c] : !adj_rows[r][c];
	endfunction

	// Staircase walk down the columns; the row position carries from column to column.
	function automatic logic find_universal_sink(input int n);
		int wr;
		int wc;
		wr = 0;
		for (wc = 0; wc < n; wc++) begin
			while (wr < n && column_fits(wr, wc))
				wr++;
			if (wr == n) begin
				wr = 0;
				while (wr < n && column_fits(wr, wc))
					wr++;
				if (wr == n) begin
					wr = 0;
					while (wr < n && !adj_rows[wc][wr])
						wr++;
					return wr == n;
				end
			end
		end
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_reg = VERTEX_COUNT_RESET;
			fill_row = 0;
			fill_col = 0;
			owed_verdicts.delete();
			fail_count <= errors;
			results_owed <= 0;
		end else begin
			if (done) begin
				if (owed_verdicts.size() == 0) begin
					$display("%0t: unexpected verdict, expected none, actual has_sink=%b",
						$time, has_sink);
					errors++;
				end else begin
					want = owed_verdicts.pop_front();
					if (has_sink !== want) begin
						$display("%0t: has_sink mismatch, expected %b, actual %b",
							$time, want, has_sink);
						errors++;
					end
				end
			end
			// A write restarts loading and drops any partial matrix.
			if (cfg_wr_en) begin
				count_reg = cfg_wr_data;
				fill_row = 0;
				fill_col = 0;
			end
			if (start && !busy) begin
				span = (count_reg > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : count_reg;
				if (span != 0) begin
					if (fill_row >= span || fill_col >= span) begin
						fill_row = 0;
						fill_col = 0;
					end
					adj_rows[fill_row][fill_col] = edge_bit;
					fill_col++;
					if (fill_col == span) begin
						fill_col = 0;
						fill_row++;
						if (fill_row == span) begin
							fill_row = 0;
							owed_verdicts.push_back(find_universal_sink(span));
						end
					end
				end
			end
			fail_count <= errors;
			results_owed <= owed_verdicts.size();
		end
	end

endmodule

@@ test/universal_sink_detector_test.sv @@
// Top of the sink detector bench: makes matrices, drives them bit by bit,
// moves the vertex count between phases and gives the verdict.
module universal_sink_detector_test;
	import usd_pkg::*;

	localparam int ITEM_GOAL      = 1450;
	localparam int WATCHDOG_LIMIT = 100000;
	localparam int TOP_COUNT      = 64;
	localparam int TAIL_BITS      = 150;

	// Shapes of generated matrices; most carry a planted sink.
	typedef enum int {
		SHAPE_SINK,
		SHAPE_SINK_FLAWED,
		SHAPE_NOISE,
		SHAPE_EMPTY,
		SHAPE_FULL
	} shape_t;

	// Ways to spoil a planted sink.
	typedef enum int {
		FLAW_MISSING_IN,
		FLAW_SELF_LOOP,
		FLAW_OUT_EDGE
	} flaw_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               edge_bit = 1'b0;
	logic               cfg_wr_en = 1'b0;
	logic [COUNT_W-1:0] cfg_wr_data = '0;
	logic               busy;
	logic               done;
	logic               has_sink;
	int                 fail_count;
	int                 results_owed;

	logic [63:0] grid [64];
	int          cur_n = TOP_COUNT;
	int          burst_left = 0;
	bit          steady = 1'b0;
	int          idle_cycles = 0;

	universal_sink_detector u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.edge_bit    (edge_bit),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.done        (done),
		.has_sink    (has_sink)
	);

	sink_verdict_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.edge_bit     (edge_bit),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.done         (done),
		.has_sink     (has_sink),
		.fail_count   (fail_count),
		.results_owed (results_owed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: any transaction, verdict or register write counts as progress.
	// The longest quiet stretch is the settle pause at the largest count.
	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_wr_en) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: watchdog, no transaction for %0d cycles", $time, idle_cycles);
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Offer one matrix bit and hold it until the block takes it. Outside steady
	// phases, drop start for a random gap at the end of each burst.
	task automatic send_bit(input logic b);
		int gap;
		if (!steady && burst_left == 0) begin
			gap = $urandom_range(0, 8);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		start <= 1'b1;
		edge_bit <= b;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		if (burst_left != 0)
			burst_left--;
	endtask

	// Send the first count bits of the grid in row-major order.
	task automatic send_grid(input int n, input int count);
		int k;
		for (k = 0; k < count; k++)
			send_bit(grid[k / n][k % n]);
	endtask

	// Drop start, wait for every owed verdict, then hold off for at least one
	// longest search.
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (results_owed != 0)
			@(posedge clk);
		repeat (2 * cur_n * cur_n + 10 * cur_n + 8) @(posedge clk);
	endtask

	// Write the vertex count on an idle block.
	task automatic set_count(input logic [COUNT_W-1:0] v);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cur_n = (v > TOP_COUNT) ? TOP_COUNT : v;
	endtask

	// Fill the grid for an n-vertex matrix of the given shape.
	function automatic void build_grid(input int n, input shape_t shape);
		int    j;
		int    r;
		int    c;
		int    density;
		flaw_t flaw;
		j = $urandom_range(0, n - 1);
		density = $urandom_range(0, 100);
		for (r = 0; r < 64; r++)
			grid[r] = '0;
		for (r = 0; r < n; r++)
			for (c = 0; c < n; c++)
				case (shape)
					SHAPE_EMPTY: grid[r][c] = 1'b0;
					SHAPE_FULL:  grid[r][c] = 1'b1;
					default:     grid[r][c] = ($urandom_range(0, 99) < density);
				endcase
		if (shape == SHAPE_SINK || shape == SHAPE_SINK_FLAWED) begin
			// Plant vertex j: everyone points at it, it points nowhere.
			for (r = 0; r < n; r++)
				grid[r][j] = (r != j);
			for (c = 0; c < n; c++)
				grid[j][c] = 1'b0;
			if (shape == SHAPE_SINK_FLAWED) begin
				flaw = flaw_t'($urandom_range(0, 2));
				if (flaw == FLAW_MISSING_IN && n < 2)
					flaw = FLAW_SELF_LOOP;
				case (flaw)
					FLAW_MISSING_IN: grid[(j + $urandom_range(1, n - 1)) % n][j] = 1'b0;
					FLAW_SELF_LOOP:  grid[j][j] = 1'b1;
					default:         grid[j][$urandom_range(0, n - 1)] = 1'b1;
				endcase
			end
		end
	endfunction

	function automatic shape_t pick_shape();
		int p;
		p = $urandom_range(0, 9);
		if (p < 5)
			return SHAPE_SINK;
		if (p < 7)
			return SHAPE_SINK_FLAWED;
		if (p < 9)
			return SHAPE_NOISE;
		return ($urandom_range(0, 1) != 0) ? SHAPE_FULL : SHAPE_EMPTY;
	endfunction

	initial begin
		int counted;
		int n;
		int k;
		int mats;
		int p;
		counted = 0;

		// Hold reset low, release it on a clock edge.
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero vertices, so these bits are ignored.
		set_count(7'd0);
		send_bit(1'b1);
		send_bit(1'b0);
		send_bit(1'b1);

		// Single vertex: a sink exactly when there is no self-loop.
		set_count(7'd1);
		build_grid(1, SHAPE_EMPTY);
		send_grid(1, 1);
		build_grid(1, SHAPE_FULL);
		send_grid(1, 1);

		// Two vertices: a clean sink, then one that is spoiled.
		set_count(7'd2);
		build_grid(2, SHAPE_SINK);
		send_grid(2, 4);
		build_grid(2, SHAPE_SINK_FLAWED);
		send_grid(2, 4);

		// Rewrite mid-load drops the partial matrix.
		set_count(7'd3);
		build_grid(3, SHAPE_FULL);
		send_grid(3, 4);
		set_count(7'd3);
		build_grid(3, SHAPE_SINK);
		send_grid(3, 9);

		// Random phases on small matrices, a few medium ones.
		while (counted < ITEM_GOAL - 3 * TAIL_BITS) begin
			steady = ($urandom_range(0, 3) == 0);
			p = $urandom_range(0, 19);
			if (p == 0) begin
				set_count(7'd0);
				k = $urandom_range(1, 4);
				repeat (k) send_bit(1'($urandom_range(0, 1)));
			end else begin
				if (p == 1)
					n = 1;
				else if (p < 16)
					n = $urandom_range(2, 6);
				else
					n = $urandom_range(7, 12);
				set_count(COUNT_W'(n));
				mats = $urandom_range(1, 5);
				repeat (mats) begin
					build_grid(n, pick_shape());
					send_grid(n, n * n);
					counted += n * n;
				end
				// Sometimes leave a partial matrix for the next write to drop.
				if (n > 1 && $urandom_range(0, 3) == 0) begin
					k = $urandom_range(1, n * n - 1);
					build_grid(n, SHAPE_NOISE);
					send_grid(n, k);
					counted += k;
				end
			end
		end

		// Largest size, a count past the maximum and all-ones in the register,
		// each with a partial load that wraps rows, the first two dropped by the next write.
		steady = 1'b0;
		set_count(7'd64);
		build_grid(TOP_COUNT, SHAPE_NOISE);
		send_grid(TOP_COUNT, TAIL_BITS);
		set_count(7'd100);
		build_grid(TOP_COUNT, SHAPE_NOISE);
		send_grid(TOP_COUNT, TAIL_BITS);
		set_count(7'd127);
		build_grid(TOP_COUNT, SHAPE_SINK_FLAWED);
		send_grid(TOP_COUNT, TAIL_BITS);

		// Drain and let the block go quiet before the verdict.
		settle();
		if (results_owed != 0)
			$display("%0t: %0d verdicts never arrived", $time, results_owed);
		if (fail_count == 0 && results_owed == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ universal_sink_detector.f @@
+incdir+src
src/usd_pkg.sv
src/universal_sink_detector.sv
test/sink_verdict_checker.sv
test/universal_sink_detector_test.sv
